/* hdl/cbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// counter and size widths follow the largest frame
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WSIZE_W = COL_W + 1;
	localparam int HSIZE_W = ROW_W + 1;

	localparam int CFG_W   = 11;
	localparam int LEVEL_W = 8;
	localparam int SUM_W   = 30;
	localparam int MATCH_W = 21;
	localparam int POS_W   = 10;
	localparam int STEP_W  = $clog2(SUM_W + 1);

	localparam int DIFF_W = ((COL_W > POS_W) ? COL_W : POS_W) + 2;
	localparam int DIFFR_W = ((ROW_W > POS_W) ? ROW_W : POS_W) + 2;

	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CIDX_W = 3;
	localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CIDX_W-1:0] REG_RED_LIMIT    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GREEN_LIMIT  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_BLUE_LIMIT   = 3'd4;

	localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 11'd64;
	localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 11'd64;
	localparam logic [LEVEL_W-1:0] RST_RED_LIMIT    = 8'd150;
	localparam logic [LEVEL_W-1:0] RST_GREEN_LIMIT  = 8'd100;
	localparam logic [LEVEL_W-1:0] RST_BLUE_LIMIT   = 8'd100;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// totals of one finished frame, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
		logic [MATCH_W-1:0] match_total;
		logic [COL_W-1:0]   half_w;
		logic [ROW_W-1:0]   half_h;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [WSIZE_W-1:0] eff_width(input logic [CFG_W-1:0] v);
		logic [WSIZE_W-1:0] r;
		if (v == '0) begin
			r = WSIZE_W'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WSIZE_W'(MAX_WIDTH);
		end else begin
			r = WSIZE_W'(v);
		end
		return r;
	endfunction

	function automatic logic [HSIZE_W-1:0] eff_height(input logic [CFG_W-1:0] v);
		logic [HSIZE_W-1:0] r;
		if (v == '0) begin
			r = HSIZE_W'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HSIZE_W'(MAX_HEIGHT);
		end else begin
			r = HSIZE_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/color_blob_centroid.sv */
`timescale 1ns / 1ps
`default_nettype none

// Color threshold blob centroid. Pixels arrive one per word in raster order and are
// taken one per clock unless full holds a frame's last pixel; a pixel matches when
// red is above red_limit and green and blue are below their limits. Column and row
// are counted against frame_width and frame_height (zero acts as one, values above
// the maximum frame size are clamped). After the last pixel of a frame one result
// word is queued: the truncated mean column and row of the matching pixels, their
// offsets from the frame centre and the match count, all zero when nothing matched.
// The two quotients come from two bit-serial dividers that run side by side. Up
// to two finished frames wait in a queue ahead of the dividers; full rises only
// on the last pixel of a frame when that queue is full, so that pixel is stalled
// until the dividers free a slot.
// Registers are written through the cfg port, which is always ready.
module color_blob_centroid
	import cbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [LEVEL_W-1:0] red_level,
	input  wire logic [LEVEL_W-1:0] green_level,
	input  wire logic [LEVEL_W-1:0] blue_level,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    found,
	output logic [POS_W-1:0]        centroid_col,
	output logic [POS_W-1:0]        centroid_row,
	output logic signed [POS_W-1:0] offset_col,
	output logic signed [POS_W-1:0] offset_row,
	output logic [MATCH_W-1:0]      match_count
);

	fifo_stat_t fifo_stat;
	frame_rec_t push_rec;
	frame_rec_t pop_rec;
	logic       rec_push;
	logic       rec_pop;

	assign cfg_ready = 1'b1;

	cbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.fifo_stat   (fifo_stat),
		.rec_push    (rec_push),
		.rec         (push_rec)
	);

	cbc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (push_rec),
		.rd_en   (rec_pop),
		.rd_data (pop_rec),
		.stat    (fifo_stat)
	);

	cbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_stat    (fifo_stat),
		.rec          (pop_rec),
		.rec_pop      (rec_pop),
		.pop          (pop),
		.empty        (empty),
		.found        (found),
		.centroid_col (centroid_col),
		.centroid_row (centroid_row),
		.offset_col   (offset_col),
		.offset_row   (offset_row),
		.match_count  (match_count)
	);

`ifndef ASSERT_OFF
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !fifo_stat.full)
		else $error("frame word pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> !fifo_stat.empty)
		else $error("frame word popped from an empty queue");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (found == (match_count != '0)))
		else $error("found flag disagrees with match count");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (centroid_col == '0 && centroid_row == '0
			&& offset_col == '0 && offset_row == '0))
		else $error("result without matches has nonzero fields");
`endif

endmodule

`default_nettype wire

/* hdl/cbc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbc_front
	import cbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [LEVEL_W-1:0] red_level,
	input  wire logic [LEVEL_W-1:0] green_level,
	input  wire logic [LEVEL_W-1:0] blue_level,
	input  wire fifo_stat_t         fifo_stat,
	output logic                    rec_push,
	output frame_rec_t              rec
);

	logic [CFG_W-1:0]   frame_width_q;
	logic [CFG_W-1:0]   frame_height_q;
	logic [LEVEL_W-1:0] red_limit_q;
	logic [LEVEL_W-1:0] green_limit_q;
	logic [LEVEL_W-1:0] blue_limit_q;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [SUM_W-1:0]   col_sum_q;
	logic [SUM_W-1:0]   row_sum_q;
	logic [MATCH_W-1:0] matches_q;

	logic [WSIZE_W-1:0] w;
	logic [HSIZE_W-1:0] h;
	logic               col_last;
	logic               row_last;
	logic               frame_last;
	logic               hit;
	logic               accept;
	logic [SUM_W-1:0]   col_sum_d;
	logic [SUM_W-1:0]   row_sum_d;
	logic [MATCH_W-1:0] matches_d;

	always_comb begin
		w          = eff_width(frame_width_q);
		h          = eff_height(frame_height_q);
		col_last   = !((WSIZE_W'(col_q) + WSIZE_W'(1)) < w);
		row_last   = !((HSIZE_W'(row_q) + HSIZE_W'(1)) < h);
		frame_last = col_last && row_last;
		hit        = (red_level > red_limit_q) && (green_level < green_limit_q)
		             && (blue_level < blue_limit_q);
		// only the frame's last word needs room in the queue
		full       = fifo_stat.full && frame_last;
		accept     = push && !full;
		col_sum_d  = hit ? col_sum_q + SUM_W'(col_q) : col_sum_q;
		row_sum_d  = hit ? row_sum_q + SUM_W'(row_q) : row_sum_q;
		matches_d  = hit ? matches_q + MATCH_W'(1) : matches_q;
		rec_push   = accept && frame_last;
		rec.col_sum = col_sum_d;
		rec.row_sum = row_sum_d;
		rec.match_total = matches_d;
		rec.half_w  = COL_W'(w >> 1);
		rec.half_h  = ROW_W'(h >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			red_limit_q    <= RST_RED_LIMIT;
			green_limit_q  <= RST_GREEN_LIMIT;
			blue_limit_q   <= RST_BLUE_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_RED_LIMIT:    red_limit_q    <= cfg_data[LEVEL_W-1:0];
				REG_GREEN_LIMIT:  green_limit_q  <= cfg_data[LEVEL_W-1:0];
				REG_BLUE_LIMIT:   blue_limit_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
			matches_q <= '0;
		end else if (accept) begin
			col_q <= col_last ? '0 : col_q + COL_W'(1);
			if (col_last) begin
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end
			if (frame_last) begin
				col_sum_q <= '0;
				row_sum_q <= '0;
				matches_q <= '0;
			end else begin
				col_sum_q <= col_sum_d;
				row_sum_q <= row_sum_d;
				matches_q <= matches_d;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/cbc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbc_fifo
	import cbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire frame_rec_t wr_data,
	input  wire logic       rd_en,
	output frame_rec_t      rd_data,
	output fifo_stat_t      stat
);

	frame_rec_t        mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	always_comb begin
		stat.full  = (count_q == FCNT_W'(FIFO_DEPTH));
		stat.empty = (count_q == '0);
		do_wr      = wr_en && !stat.full;
		do_rd      = rd_en && !stat.empty;
		rd_data    = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + FCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - FCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/cbc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbc_div
	import cbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SUM_W-1:0]   dividend,
	input  wire logic [MATCH_W-1:0] divisor,
	output logic                    busy,
	output logic [SUM_W-1:0]        quotient
);

	// restoring divide, one quotient bit per cycle
	logic [MATCH_W:0]   rem_q;
	logic [SUM_W-1:0]   quo_q;
	logic [MATCH_W-1:0] div_q;
	logic [STEP_W-1:0]  step_q;
	logic [MATCH_W:0]   trial;
	logic               ge;

	always_comb begin
		busy     = (step_q != '0);
		trial    = {rem_q[MATCH_W-1:0], quo_q[SUM_W-1]};
		ge       = (trial >= {1'b0, div_q});
		quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(SUM_W);
		end else if (busy) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? trial - {1'b0, div_q} : trial;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* hdl/cbc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbc_back
	import cbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fifo_stat_t         fifo_stat,
	input  wire frame_rec_t         rec,
	output logic                    rec_pop,
	input  wire logic               pop,
	output logic                    empty,
	output logic                    found,
	output logic [POS_W-1:0]        centroid_col,
	output logic [POS_W-1:0]        centroid_row,
	output logic signed [POS_W-1:0] offset_col,
	output logic signed [POS_W-1:0] offset_row,
	output logic [MATCH_W-1:0]      match_count
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic               state_q;
	frame_rec_t         rec_q;
	logic               out_valid_q;
	logic               col_busy;
	logic               row_busy;
	logic [SUM_W-1:0]   col_quo;
	logic [SUM_W-1:0]   row_quo;
	logic               start;
	logic               load;
	logic [POS_W-1:0]   cx;
	logic [POS_W-1:0]   cy;
	logic signed [DIFF_W-1:0]  dx;
	logic signed [DIFFR_W-1:0] dy;
	logic [POS_W-1:0]   ox;
	logic [POS_W-1:0]   oy;
	logic               any;

	cbc_div u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (rec.col_sum),
		.divisor  (rec.match_total),
		.busy     (col_busy),
		.quotient (col_quo)
	);

	cbc_div u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (rec.row_sum),
		.divisor  (rec.match_total),
		.busy     (row_busy),
		.quotient (row_quo)
	);

	always_comb begin
		start   = (state_q == S_IDLE) && !fifo_stat.empty;
		rec_pop = start;
		load    = (state_q == S_RUN) && !col_busy && !row_busy && (!out_valid_q || pop);
		empty   = !out_valid_q;
		any     = (rec_q.match_total != '0);

		cx = (|col_quo[SUM_W-1:POS_W]) ? POS_MAX : col_quo[POS_W-1:0];
		cy = (|row_quo[SUM_W-1:POS_W]) ? POS_MAX : row_quo[POS_W-1:0];
		dx = signed'(DIFF_W'(cx)) - signed'(DIFF_W'(rec_q.half_w));
		dy = signed'(DIFFR_W'(cy)) - signed'(DIFFR_W'(rec_q.half_h));

		// clamp to the signed range of the offset ports
		if (dx > signed'(DIFF_W'(2 ** (POS_W - 1) - 1))) begin
			ox = {1'b0, {(POS_W-1){1'b1}}};
		end else if (dx < -signed'(DIFF_W'(2 ** (POS_W - 1)))) begin
			ox = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			ox = dx[POS_W-1:0];
		end
		if (dy > signed'(DIFFR_W'(2 ** (POS_W - 1) - 1))) begin
			oy = {1'b0, {(POS_W-1){1'b1}}};
		end else if (dy < -signed'(DIFFR_W'(2 ** (POS_W - 1)))) begin
			oy = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			oy = dy[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rec_q <= rec;
		end
		if (load) begin
			found        <= any;
			centroid_col <= any ? cx : '0;
			centroid_row <= any ? cy : '0;
			offset_col   <= any ? signed'(ox) : '0;
			offset_row   <= any ? signed'(oy) : '0;
			match_count  <= rec_q.match_total;
		end
	end

endmodule

`default_nettype wire

/* tb/centroid_checker.sv */
`timescale 1ns / 1ps

module centroid_checker
	import cbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               push,
	input  logic               full,
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] green_level,
	input  logic [LEVEL_W-1:0] blue_level,
	input  logic               empty,
	input  logic               pop,
	input  logic               found,
	input  logic [POS_W-1:0]   centroid_col,
	input  logic [POS_W-1:0]   centroid_row,
	input  logic [POS_W-1:0]   offset_col,
	input  logic [POS_W-1:0]   offset_row,
	input  logic [MATCH_W-1:0] match_count,
	output int                 fail_count,
	output int                 centroids_due
);

	localparam int OFS_HI = 2 ** (POS_W - 1) - 1;
	localparam int OFS_LO = -(2 ** (POS_W - 1));

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   ccol;
		logic [POS_W-1:0]   crow;
		logic [POS_W-1:0]   ocol;
		logic [POS_W-1:0]   orow;
		logic [MATCH_W-1:0] hits;
	} centroid_t;

	centroid_t pending_centroids[$];
	int errs = 0;

	// shadow of the register file
	logic [CFG_W-1:0]   width_reg;
	logic [CFG_W-1:0]   height_reg;
	logic [LEVEL_W-1:0] red_thr;
	logic [LEVEL_W-1:0] green_thr;
	logic [LEVEL_W-1:0] blue_thr;

	// raster position and running totals of the current frame
	logic [COL_W-1:0]   col_pos;
	logic [ROW_W-1:0]   row_pos;
	logic [SUM_W-1:0]   col_acc;
	logic [SUM_W-1:0]   row_acc;
	logic [MATCH_W-1:0] hit_cnt;

	function automatic int frame_span(input logic [CFG_W-1:0] v, input int limit);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > limit) begin
			return limit;
		end
		return int'(v);
	endfunction

	function automatic logic [POS_W-1:0] mean_pos(input logic [SUM_W-1:0] q);
		if (q > SUM_W'(POS_MAX)) begin
			return POS_MAX;
		end
		return q[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] centre_offset(input int d);
		if (d > OFS_HI) begin
			d = OFS_HI;
		end
		if (d < OFS_LO) begin
			d = OFS_LO;
		end
		return POS_W'(d);
	endfunction

	task automatic take_pixel(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
		input logic [LEVEL_W-1:0] b);
		int w;
		int h;
		centroid_t c;
		w = frame_span(width_reg, MAX_WIDTH);
		h = frame_span(height_reg, MAX_HEIGHT);
		if (r > red_thr && g < green_thr && b < blue_thr) begin
			col_acc = col_acc + SUM_W'(col_pos);
			row_acc = row_acc + SUM_W'(row_pos);
			hit_cnt = hit_cnt + 1'b1;
		end
		// a shrunk size ends the row or frame as soon as the counter reaches it
		if (int'(col_pos) + 1 < w) begin
			col_pos = col_pos + 1'b1;
		end else begin
			col_pos = '0;
			if (int'(row_pos) + 1 < h) begin
				row_pos = row_pos + 1'b1;
			end else begin
				row_pos = '0;
				c = '0;
				if (hit_cnt != '0) begin
					c.found = 1'b1;
					c.ccol = mean_pos(col_acc / SUM_W'(hit_cnt));
					c.crow = mean_pos(row_acc / SUM_W'(hit_cnt));
					c.ocol = centre_offset(int'(c.ccol) - w / 2);
					c.orow = centre_offset(int'(c.crow) - h / 2);
					c.hits = hit_cnt;
				end
				pending_centroids.push_back(c);
				col_acc = '0;
				row_acc = '0;
				hit_cnt = '0;
			end
		end
	endtask

	task automatic check_centroid();
		centroid_t seen;
		centroid_t want;
		seen.found = found;
		seen.ccol = centroid_col;
		seen.crow = centroid_row;
		seen.ocol = offset_col;
		seen.orow = offset_row;
		seen.hits = match_count;
		if (pending_centroids.size() == 0) begin
			errs++;
			if (errs <= 10) begin
				$display("%0t: unexpected word found=%0d col=%0d row=%0d count=%0d", $realtime,
					seen.found, seen.ccol, seen.crow, seen.hits);
			end
		end else begin
			want = pending_centroids.pop_front();
			if (want.found !== seen.found || want.ccol !== seen.ccol ||
				want.crow !== seen.crow || want.ocol !== seen.ocol ||
				want.orow !== seen.orow || want.hits !== seen.hits) begin
				errs++;
				if (errs <= 10) begin
					$display("%0t: expected found=%0d col=%0d row=%0d ocol=%0d orow=%0d count=%0d",
						$realtime, want.found, want.ccol, want.crow, $signed(want.ocol),
						$signed(want.orow), want.hits);
					$display("%0t: actual   found=%0d col=%0d row=%0d ocol=%0d orow=%0d count=%0d",
						$realtime, seen.found, seen.ccol, seen.crow, $signed(seen.ocol),
						$signed(seen.orow), seen.hits);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			red_thr = RST_RED_LIMIT;
			green_thr = RST_GREEN_LIMIT;
			blue_thr = RST_BLUE_LIMIT;
			col_pos = '0;
			row_pos = '0;
			col_acc = '0;
			row_acc = '0;
			hit_cnt = '0;
			pending_centroids.delete();
		end else begin
			if (pop && !empty) begin
				check_centroid();
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
					end
					REG_RED_LIMIT: begin
						red_thr = cfg_data[LEVEL_W-1:0];
					end
					REG_GREEN_LIMIT: begin
						green_thr = cfg_data[LEVEL_W-1:0];
					end
					REG_BLUE_LIMIT: begin
						blue_thr = cfg_data[LEVEL_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (push && !full) begin
				take_pixel(red_level, green_level, blue_level);
			end
		end
		fail_count <= errs;
		centroids_due <= pending_centroids.size();
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import cbc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               push = 1'b0;
	logic               full;
	logic [LEVEL_W-1:0] red_level = '0;
	logic [LEVEL_W-1:0] green_level = '0;
	logic [LEVEL_W-1:0] blue_level = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic               found;
	logic [POS_W-1:0]   centroid_col;
	logic [POS_W-1:0]   centroid_row;
	logic [POS_W-1:0]   offset_col;
	logic [POS_W-1:0]   offset_row;
	logic [MATCH_W-1:0] match_count;

	int fail_count;
	int centroids_due;

	// limits last written, used to steer pixels toward or away from a match
	int cur_red = RST_RED_LIMIT;
	int cur_green = RST_GREEN_LIMIT;
	int cur_blue = RST_BLUE_LIMIT;

	bit steady_send = 1'b0;
	bit pop_steady = 1'b0;
	int stall_left = 0;

	color_blob_centroid uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.red_level(red_level),
		.green_level(green_level),
		.blue_level(blue_level),
		.empty(empty),
		.pop(pop),
		.found(found),
		.centroid_col(centroid_col),
		.centroid_row(centroid_row),
		.offset_col(offset_col),
		.offset_row(offset_row),
		.match_count(match_count)
	);

	centroid_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.red_level(red_level),
		.green_level(green_level),
		.blue_level(blue_level),
		.empty(empty),
		.pop(pop),
		.found(found),
		.centroid_col(centroid_col),
		.centroid_row(centroid_row),
		.offset_col(offset_col),
		.offset_row(offset_row),
		.match_count(match_count),
		.fail_count(fail_count),
		.centroids_due(centroids_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(8, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!pop_steady && $urandom_range(0, 3) == 0) begin
			pop <= 1'b0;
			stall_left <= gap_len() - 1;
		end else begin
			pop <= 1'b1;
		end
		if ($urandom_range(0, 149) == 0) begin
			pop_steady <= !pop_steady;
		end
	end

	task automatic send_pixel(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
		input logic [LEVEL_W-1:0] b);
		int gap;
		gap = 0;
		if (!steady_send && $urandom_range(0, 9) < 4) begin
			gap = gap_len();
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		red_level <= r;
		green_level <= g;
		blue_level <= b;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic feed_pixel(input bit hit);
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
		r = LEVEL_W'($urandom);
		g = LEVEL_W'($urandom);
		b = LEVEL_W'($urandom);
		if (hit) begin
			if (cur_red < 255) begin
				r = LEVEL_W'($urandom_range(255, cur_red + 1));
			end
			if (cur_green > 0) begin
				g = LEVEL_W'($urandom_range(cur_green - 1, 0));
			end
			if (cur_blue > 0) begin
				b = LEVEL_W'($urandom_range(cur_blue - 1, 0));
			end
		end else if ($urandom_range(0, 1) == 0) begin
			r = LEVEL_W'($urandom_range(cur_red, 0));
		end
		send_pixel(r, g, b);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_all(input int w, input int h, input int r, input int g, input int b);
		write_reg(REG_FRAME_WIDTH, CFG_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
		write_reg(REG_RED_LIMIT, CFG_W'(r));
		write_reg(REG_GREEN_LIMIT, CFG_W'(g));
		write_reg(REG_BLUE_LIMIT, CFG_W'(b));
		cfg_valid <= 1'b0;
		cur_red = r;
		cur_green = g;
		cur_blue = b;
	endtask

	// hold the sender until every frame result is back, then cover the divider
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (centroids_due != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic int pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) begin
			return 0;
		end
		if (p < 80) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(5, 12);
	endfunction

	function automatic int pick_limit();
		int p;
		p = $urandom_range(0, 99);
		if (p < 6) begin
			return 0;
		end
		if (p < 12) begin
			return 255;
		end
		return $urandom_range(0, 255);
	endfunction

	initial begin
		int w;
		int h;
		int n;
		int hit_pct;
		int random_sent;
		random_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strict compares right at the limits
		program_all(2, 2, 100, 200, 200);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd101, 8'd199, 8'd199);
		send_pixel(8'd100, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd200, 8'd0);
		// frame with no match
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		drain_results();

		// zero size acts as one: every pixel is a frame
		program_all(0, 0, 0, 255, 255);
		send_pixel(8'd1, 8'd254, 8'd254);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd0);
		drain_results();
		program_all(0, 0, 255, 0, 0);
		send_pixel(8'd255, 8'd0, 8'd0);
		drain_results();

		// width shrinks in the middle of a frame
		program_all(4, 3, 150, 100, 100);
		repeat (6) feed_pixel(1'b1);
		drain_results();
		write_reg(REG_FRAME_WIDTH, CFG_W'(1));
		cfg_valid <= 1'b0;
		feed_pixel(1'b0);
		feed_pixel(1'b1);
		drain_results();

		// oversize width clamps to the maximum; shrinking it afterwards saturates the offset
		program_all(2047, 2, 150, 100, 100);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			feed_pixel(i >= 900 && ($urandom_range(0, 2) != 0 || i == MAX_WIDTH - 1));
		end
		drain_results();
		write_reg(REG_FRAME_WIDTH, CFG_W'(2));
		cfg_valid <= 1'b0;
		feed_pixel(1'b0);
		feed_pixel(1'b0);
		drain_results();

		// random frames; a partial tail carries into the next setting
		while (random_sent < 404) begin
			w = pick_size();
			h = pick_size();
			program_all(w, h, pick_limit(), pick_limit(), pick_limit());
			steady_send = ($urandom_range(0, 4) == 0);
			hit_pct = $urandom_range(0, 100);
			n = $urandom_range(1, 4) * (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
			if ($urandom_range(0, 3) == 0) begin
				n = n + $urandom_range(1, 10);
			end
			if (n > 404 - random_sent) begin
				n = 404 - random_sent;
			end
			repeat (n) begin
				feed_pixel($urandom_range(0, 99) < hit_pct);
				random_sent++;
			end
			drain_results();
		end

		if (fail_count == 0 && centroids_due == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
